[rtl/core/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PWTS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pwts assertion failed");
`define PWTS_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("pwts assertion failed");
`else
`define PWTS_ASSERT(label, prop)
`define PWTS_ASSERT_NEXT(label, cause, effect)
`endif
`endif

[rtl/core/pwts_pkg.sv]
`default_nettype none
package pwts_pkg;

    localparam int COORD_W     = 32;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int FRAC_W      = 16;
    localparam int ROW_W       = 50;
    localparam int SCALE_W     = 16;
    localparam int NUM_W       = SCALE_W + ROW_W;
    localparam int Q_W         = 17;
    localparam int REM_W       = ROW_W + 1;
    localparam int DIV_STAGES  = Q_W;
    localparam int SIZE_W      = 13;
    localparam int W_MIN_RAW   = 66;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int NUM_ROWS    = 3;
    localparam int NUM_COEFS   = 4;
    localparam int NUM_COEF_REGS = 6;
    localparam int RESET_WIDTH  = 1920;
    localparam int RESET_HEIGHT = 1080;

    localparam int ROW_SEL_X = 0;
    localparam int ROW_SEL_Y = 1;
    localparam int ROW_SEL_W = 2;

    typedef enum logic [2:0] {
        REG_X_AB   = 3'd0,
        REG_X_CD   = 3'd1,
        REG_Y_AB   = 3'd2,
        REG_Y_CD   = 3'd3,
        REG_W_AB   = 3'd4,
        REG_W_CD   = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_VISIBLE   = 2'd0,
        ST_BEHIND    = 2'd1,
        ST_OFFSCREEN = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
    } point_t;

    typedef struct packed {
        logic [Q_W-1:0] screen_x;
        logic [Q_W-1:0] screen_y;
        status_t        status;
    } result_t;

    typedef struct packed {
        logic [NUM_ROWS-1:0][NUM_COEFS-1:0][COORD_W-1:0] coef;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } ctl_t;

endpackage
`default_nettype wire

[rtl/core/pwts_regs.sv]
`default_nettype none
module pwts_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pwts_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pwts_pkg::DATA_W-1:0]   pwdata,
    output logic      [pwts_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output pwts_pkg::cfg_t                     cfg
);

    logic [pwts_pkg::DATA_W-1:0] coef_reg [pwts_pkg::NUM_COEF_REGS];
    logic [pwts_pkg::SIZE_W-1:0] width_reg;
    logic [pwts_pkg::SIZE_W-1:0] height_reg;
    logic                        wr;
    pwts_pkg::reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = pwts_pkg::reg_idx_t'(paddr[pwts_pkg::ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pwts_pkg::NUM_COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
            width_reg  <= pwts_pkg::SIZE_W'(pwts_pkg::RESET_WIDTH);
            height_reg <= pwts_pkg::SIZE_W'(pwts_pkg::RESET_HEIGHT);
        end
        else if (wr)
        begin
            case (idx)
                pwts_pkg::REG_X_AB:   coef_reg[0] <= pwdata;
                pwts_pkg::REG_X_CD:   coef_reg[1] <= pwdata;
                pwts_pkg::REG_Y_AB:   coef_reg[2] <= pwdata;
                pwts_pkg::REG_Y_CD:   coef_reg[3] <= pwdata;
                pwts_pkg::REG_W_AB:   coef_reg[4] <= pwdata;
                pwts_pkg::REG_W_CD:   coef_reg[5] <= pwdata;
                pwts_pkg::REG_WIDTH:  width_reg   <= pwdata[pwts_pkg::SIZE_W-1:0];
                pwts_pkg::REG_HEIGHT: height_reg  <= pwdata[pwts_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            pwts_pkg::REG_X_AB:   prdata = coef_reg[0];
            pwts_pkg::REG_X_CD:   prdata = coef_reg[1];
            pwts_pkg::REG_Y_AB:   prdata = coef_reg[2];
            pwts_pkg::REG_Y_CD:   prdata = coef_reg[3];
            pwts_pkg::REG_W_AB:   prdata = coef_reg[4];
            pwts_pkg::REG_W_CD:   prdata = coef_reg[5];
            pwts_pkg::REG_WIDTH:  prdata = pwts_pkg::DATA_W'(width_reg);
            pwts_pkg::REG_HEIGHT: prdata = pwts_pkg::DATA_W'(height_reg);
            default:              prdata = '0;
        endcase
    end

    // Each row owns two registers: elements a,b in the first, c,d in the second.
    always_comb
    begin
        for (int r = 0; r < pwts_pkg::NUM_ROWS; r++)
        begin
            cfg.coef[r][0] = coef_reg[2*r][pwts_pkg::COORD_W-1:0];
            cfg.coef[r][1] = coef_reg[2*r][pwts_pkg::DATA_W-1:pwts_pkg::COORD_W];
            cfg.coef[r][2] = coef_reg[2*r+1][pwts_pkg::COORD_W-1:0];
            cfg.coef[r][3] = coef_reg[2*r+1][pwts_pkg::DATA_W-1:pwts_pkg::COORD_W];
        end
        cfg.width  = width_reg;
        cfg.height = height_reg;
    end

endmodule
`default_nettype wire

[rtl/core/pwts_xform.sv]
`default_nettype none
module pwts_xform (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire pwts_pkg::point_t             point,
    input  wire pwts_pkg::cfg_t               cfg,
    output pwts_pkg::ctl_t                    ctl,
    output logic [pwts_pkg::NUM_W-1:0]        num_x,
    output logic [pwts_pkg::NUM_W-1:0]        num_y,
    output logic [pwts_pkg::ROW_W-1:0]        den
);

    localparam logic signed [pwts_pkg::ROW_W-1:0] W_MIN =
        pwts_pkg::ROW_W'(pwts_pkg::W_MIN_RAW);

    logic signed [pwts_pkg::COORD_W-1:0] wv [3];
    logic signed [pwts_pkg::PROD_W-1:0]  prod_next [pwts_pkg::NUM_ROWS][3];
    logic signed [pwts_pkg::PROD_W-1:0]  prod_reg  [pwts_pkg::NUM_ROWS][3];
    logic                                v1_reg;

    logic signed [pwts_pkg::ROW_W-1:0]   row_next [pwts_pkg::NUM_ROWS];
    logic signed [pwts_pkg::ROW_W-1:0]   row_reg  [pwts_pkg::NUM_ROWS];
    logic                                v2_reg;

    logic signed [pwts_pkg::ROW_W:0]     cw_e, cx_e, cy_e, nx_e, ny_e;
    logic                                behind, off;
    pwts_pkg::status_t                   st_next;
    pwts_pkg::status_t                   st3_reg;
    logic                                v3_reg;
    logic [pwts_pkg::ROW_W-1:0]          nx_reg, ny_reg, den3_reg;

    logic [pwts_pkg::SCALE_W-1:0]        scale_x, scale_y;
    logic                                valid_reg;
    pwts_pkg::status_t                   status_reg;
    logic [pwts_pkg::NUM_W-1:0]          numx_reg, numy_reg;
    logic [pwts_pkg::ROW_W-1:0]          den_reg;

    assign wv[0] = point.world_x;
    assign wv[1] = point.world_y;
    assign wv[2] = point.world_z;

    // Stage 1: nine full products
    always_comb
    begin
        for (int r = 0; r < pwts_pkg::NUM_ROWS; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = signed'(cfg.coef[r][c]) * wv[c];
            end
        end
    end

    // Stage 2: floor each product to Q16.16 and add the translation term
    always_comb
    begin
        for (int r = 0; r < pwts_pkg::NUM_ROWS; r++)
        begin
            row_next[r] = pwts_pkg::ROW_W'(prod_reg[r][0] >>> pwts_pkg::FRAC_W)
                        + pwts_pkg::ROW_W'(prod_reg[r][1] >>> pwts_pkg::FRAC_W)
                        + pwts_pkg::ROW_W'(prod_reg[r][2] >>> pwts_pkg::FRAC_W)
                        + pwts_pkg::ROW_W'(signed'(cfg.coef[r][3]));
        end
    end

    // Stage 3: classify and form the numerators
    always_comb
    begin
        cw_e   = (pwts_pkg::ROW_W+1)'(row_reg[pwts_pkg::ROW_SEL_W]);
        cx_e   = (pwts_pkg::ROW_W+1)'(row_reg[pwts_pkg::ROW_SEL_X]);
        cy_e   = (pwts_pkg::ROW_W+1)'(row_reg[pwts_pkg::ROW_SEL_Y]);
        nx_e   = cw_e + cx_e;
        ny_e   = cw_e - cy_e;
        behind = row_reg[pwts_pkg::ROW_SEL_W] < W_MIN;
        off    = (cx_e < -cw_e) || (cx_e > cw_e) || (cy_e < -cw_e) || (cy_e > cw_e);
        if (behind)
            st_next = pwts_pkg::ST_BEHIND;
        else if (off)
            st_next = pwts_pkg::ST_OFFSCREEN;
        else
            st_next = pwts_pkg::ST_VISIBLE;
    end

    // Stage 4: scale by 8 * viewport size
    assign scale_x = {cfg.width, 3'b000};
    assign scale_y = {cfg.height, 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        row_reg    <= row_next;
        st3_reg    <= st_next;
        nx_reg     <= nx_e[pwts_pkg::ROW_W-1:0];
        ny_reg     <= ny_e[pwts_pkg::ROW_W-1:0];
        den3_reg   <= row_reg[pwts_pkg::ROW_SEL_W];
        status_reg <= st3_reg;
        numx_reg   <= scale_x * nx_reg;
        numy_reg   <= scale_y * ny_reg;
        den_reg    <= den3_reg;
    end

    assign ctl   = '{valid: valid_reg, status: status_reg};
    assign num_x = numx_reg;
    assign num_y = numy_reg;
    assign den   = den_reg;

endmodule
`default_nettype wire

[rtl/core/pwts_div.sv]
`default_nettype none
module pwts_div (
    input  wire logic                      clk,
    input  wire logic [pwts_pkg::NUM_W-1:0] num,
    input  wire logic [pwts_pkg::ROW_W-1:0] den,
    output logic      [pwts_pkg::Q_W-1:0]   quo
);

    localparam int NS = pwts_pkg::DIV_STAGES;

    logic [pwts_pkg::REM_W-1:0] rem_reg [NS];
    logic [pwts_pkg::Q_W-1:0]   low_reg [NS];
    logic [pwts_pkg::Q_W-1:0]   q_reg   [NS];
    logic [pwts_pkg::ROW_W-1:0] den_reg [NS];

    logic [pwts_pkg::REM_W-1:0] rem_prev [NS];
    logic [pwts_pkg::Q_W-1:0]   low_prev [NS];
    logic [pwts_pkg::Q_W-1:0]   q_prev   [NS];
    logic [pwts_pkg::ROW_W-1:0] den_prev [NS];

    // The quotient fits Q_W bits, so the numerator bits above them are already
    // below the divisor and seed the partial remainder.
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [pwts_pkg::REM_W-1:0] trial;
        logic [pwts_pkg::REM_W-1:0] dext;
        logic                       ge;

        if (s == 0)
        begin : g_entry
            assign rem_prev[s] = pwts_pkg::REM_W'(num[pwts_pkg::NUM_W-1:pwts_pkg::Q_W]);
            assign low_prev[s] = num[pwts_pkg::Q_W-1:0];
            assign q_prev[s]   = '0;
            assign den_prev[s] = den;
        end
        else
        begin : g_chain
            assign rem_prev[s] = rem_reg[s-1];
            assign low_prev[s] = low_reg[s-1];
            assign q_prev[s]   = q_reg[s-1];
            assign den_prev[s] = den_reg[s-1];
        end

        assign trial = {rem_prev[s][pwts_pkg::REM_W-2:0], low_prev[s][pwts_pkg::Q_W-1]};
        assign dext  = {1'b0, den_prev[s]};
        assign ge    = trial >= dext;

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= ge ? (trial - dext) : trial;
            low_reg[s] <= {low_prev[s][pwts_pkg::Q_W-2:0], 1'b0};
            q_reg[s]   <= {q_prev[s][pwts_pkg::Q_W-2:0], ge};
            den_reg[s] <= den_prev[s];
        end
    end

    assign quo = q_reg[NS-1];

endmodule
`default_nettype wire

[rtl/core/perspective_world_to_screen.sv]
`default_nettype none
`include "assert_macros.svh"
// Perspective world-to-screen projection.
//
// Input channel: drive point (world x, y, z in signed Q16.16) and raise start;
// the beat is taken at any rising edge where start is high and busy is low.
// busy never rises, so a new point may be offered in every cycle.
// Output channel: done pulses for one cycle with result (screen x, y in
// unsigned Q13.4 and a status code). The receiver cannot stall; every beat
// must be taken in the cycle it is shown.
// Throughput: one point per clock, any mix of outcomes. The pipeline is
// made of four transform stages (product, row sum, clip test, viewport
// scale), one stage per quotient bit of the 17-bit restoring divide, and
// the output register.
// Configuration: APB, 64-bit data, register i at byte address 8*i; write only
// while no point is in flight. Reset clears the pipeline valids, zeroes the
// matrix and loads a 1920x1080 viewport.
module perspective_world_to_screen (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire pwts_pkg::point_t             point,
    output logic                              done,
    output pwts_pkg::result_t                 result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pwts_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pwts_pkg::DATA_W-1:0]  pwdata,
    output logic      [pwts_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int NS = pwts_pkg::DIV_STAGES;

    pwts_pkg::cfg_t             cfg;
    pwts_pkg::ctl_t             xf_ctl;
    logic [pwts_pkg::NUM_W-1:0] num_x, num_y;
    logic [pwts_pkg::ROW_W-1:0] den;
    logic [pwts_pkg::Q_W-1:0]   quo_x, quo_y;

    // Control travels beside the divider, one slot per quotient stage.
    logic                       ctl_valid_reg  [NS];
    pwts_pkg::status_t          ctl_status_reg [NS];
    logic                       done_reg;
    pwts_pkg::result_t          result_reg;
    pwts_pkg::result_t          result_next;
    logic                       in_valid;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    pwts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwts_xform u_xform (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .point    (point),
        .cfg      (cfg),
        .ctl      (xf_ctl),
        .num_x    (num_x),
        .num_y    (num_y),
        .den      (den)
    );

    pwts_div u_div_x (
        .clk (clk),
        .num (num_x),
        .den (den),
        .quo (quo_x)
    );

    pwts_div u_div_y (
        .clk (clk),
        .num (num_y),
        .den (den),
        .quo (quo_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                ctl_valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_valid_reg[0] <= xf_ctl.valid;
            for (int s = 1; s < NS; s++)
            begin
                ctl_valid_reg[s] <= ctl_valid_reg[s-1];
            end
            done_reg <= ctl_valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_status_reg[0] <= xf_ctl.status;
        for (int s = 1; s < NS; s++)
        begin
            ctl_status_reg[s] <= ctl_status_reg[s-1];
        end
        result_reg <= result_next;
    end

    // Drop the coordinates unless the point is visible.
    always_comb
    begin
        result_next.status = ctl_status_reg[NS-1];
        if (ctl_status_reg[NS-1] == pwts_pkg::ST_VISIBLE)
        begin
            result_next.screen_x = quo_x;
            result_next.screen_y = quo_y;
        end
        else
        begin
            result_next.screen_x = '0;
            result_next.screen_y = '0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `PWTS_ASSERT(a_masked_coords, (done && result.status != pwts_pkg::ST_VISIBLE) |-> (result.screen_x == '0 && result.screen_y == '0))
    `PWTS_ASSERT(a_x_in_view, (done && result.status == pwts_pkg::ST_VISIBLE) |-> (result.screen_x <= {cfg.width, 4'b0000}))
    `PWTS_ASSERT(a_y_in_view, (done && result.status == pwts_pkg::ST_VISIBLE) |-> (result.screen_y <= {cfg.height, 4'b0000}))
    `PWTS_ASSERT_NEXT(a_tail_to_done, ctl_valid_reg[NS-1], done)

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pwts_pkg::*;

    // Generous cycle ceiling: ~700 points, each possibly preceded by an idle burst,
    // plus config phases and pipeline drains, taken many times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DRAIN  = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    point_t point = '0;
    logic done;
    result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // Shadow copy of the register file, indexed by reg_idx_t.
    logic [DATA_W-1:0] shadow_regs [8];
    result_t pending_pixels [$];
    int mismatches = 0;
    int cycles = 0;
    bit idle_on = 1'b1;

    perspective_world_to_screen DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // One matrix row: each product floored to Q16.16, then summed exactly.
    function automatic longint row_dot(input logic [63:0] ab, input logic [63:0] cd,
                                       input point_t p);
        longint c0, c1, c2, c3, px, py, pz;
        c0 = longint'($signed(ab[31:0]));
        c1 = longint'($signed(ab[63:32]));
        c2 = longint'($signed(cd[31:0]));
        c3 = longint'($signed(cd[63:32]));
        px = longint'(p.world_x);
        py = longint'(p.world_y);
        pz = longint'(p.world_z);
        return ((c0 * px) >>> FRAC_W) + ((c1 * py) >>> FRAC_W)
             + ((c2 * pz) >>> FRAC_W) + c3;
    endfunction

    // floor(size * 8 * n / w), computed wide so nothing wraps.
    function automatic logic [Q_W-1:0] pixel_ratio(input logic [63:0] size,
                                                   input longint n, input longint w);
        bit [127:0] num;
        bit [127:0] q;
        num = 128'(size[SIZE_W-1:0]) * 128'd8 * 128'(n);
        q = num / 128'(w);
        return q[Q_W-1:0];
    endfunction

    function automatic result_t project_point(input point_t p);
        result_t r;
        longint cw, cx, cy;
        r = '0;
        cw = row_dot(shadow_regs[REG_W_AB], shadow_regs[REG_W_CD], p);
        if (cw < W_MIN_RAW)
        begin
            r.status = ST_BEHIND;
            return r;
        end
        cx = row_dot(shadow_regs[REG_X_AB], shadow_regs[REG_X_CD], p);
        cy = row_dot(shadow_regs[REG_Y_AB], shadow_regs[REG_Y_CD], p);
        if (cx < -cw || cx > cw || cy < -cw || cy > cw)
        begin
            r.status = ST_OFFSCREEN;
            return r;
        end
        r.screen_x = pixel_ratio(shadow_regs[REG_WIDTH], cw + cx, cw);
        r.screen_y = pixel_ratio(shadow_regs[REG_HEIGHT], cw - cy, cw);
        r.status = ST_VISIBLE;
        return r;
    endfunction

    // Check each result beat against the oldest pending pixel; sample the
    // pre-edge value so ordering within the step does not matter.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (result.screen_x !== want.screen_x)
                    report_mismatch("screen_x", result.screen_x, want.screen_x);
                if (result.screen_y !== want.screen_y)
                    report_mismatch("screen_y", result.screen_y, want.screen_y);
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
            end
        end
    end

    // Setup cycle, then access cycle; the write lands on the access edge.
    // Return to idle after so back-to-back writes never restack psel.
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_WIDTH || idx == REG_HEIGHT)
            shadow_regs[idx] = {51'd0, value[SIZE_W-1:0]};
        else
            shadow_regs[idx] = value;
        @(posedge clk);
    endtask

    // Drop start, let the pipeline empty and settle.
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic load_matrix(input logic [63:0] xab, input logic [63:0] xcd,
                               input logic [63:0] yab, input logic [63:0] ycd,
                               input logic [63:0] wab, input logic [63:0] wcd);
        drain_pipe();
        write_reg(REG_X_AB, xab);
        write_reg(REG_X_CD, xcd);
        write_reg(REG_Y_AB, yab);
        write_reg(REG_Y_CD, ycd);
        write_reg(REG_W_AB, wab);
        write_reg(REG_W_CD, wcd);
    endtask

    task automatic load_viewport(input logic [12:0] w, input logic [12:0] h);
        drain_pipe();
        write_reg(REG_WIDTH, {51'd0, w});
        write_reg(REG_HEIGHT, {51'd0, h});
    endtask

    // Send one point beat; an idle burst always waits on a clock edge so
    // start never falls and rises in the same step.
    task automatic send_point(input point_t p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(project_point(p));
    endtask

    function automatic point_t make_point(input int x, input int y, input int z);
        point_t p;
        p.world_x = x;
        p.world_y = y;
        p.world_z = z;
        return p;
    endfunction

    function automatic logic [63:0] coef_pair(input int lo, input int hi);
        return {32'(hi), 32'(lo)};
    endfunction

    // Small signed Q16.16 value in +-range whole units.
    function automatic int small_fixed(input int range);
        return int'($urandom_range(0, 2 * range * 65536)) - range * 65536;
    endfunction

    // Zero matrix after reset: w is always zero, so every point is behind.
    task automatic test_reset_defaults();
        send_point(make_point(0, 0, 0));
        send_point(make_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000));
        send_point(make_point(65536, -65536, 100 * 65536));
    endtask

    // Identity-like projection: clip x = world x, clip y = world y, w = z.
    task automatic test_directed_edges();
        load_matrix(coef_pair(65536, 0), coef_pair(0, 0),
                    coef_pair(0, 65536), coef_pair(0, 0),
                    coef_pair(0, 0), coef_pair(65536, 0));
        send_point(make_point(0, 0, 65));             // just under near limit
        send_point(make_point(0, 0, 66));             // exactly at near limit
        send_point(make_point(66, -66, 66));          // corners on the edge
        send_point(make_point(-66, 66, 66));
        send_point(make_point(67, 0, 66));            // one past the edge
        send_point(make_point(0, -67, 66));
        send_point(make_point(32'h7FFFFFFF, 0, 32'h7FFFFFFF));
        send_point(make_point(32'h80000001, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_point(make_point(0, 0, 32'h80000000));   // far behind
        send_point(make_point(12345, -54321, 1000000));
        // zero size: visibility unchanged, coordinate on that axis is zero
        load_viewport(13'd0, 13'd0);
        send_point(make_point(3000, -2000, 65536));
        send_point(make_point(66, 66, 66));
        // largest width the field holds, with a 4096 height
        load_viewport(13'd8191, 13'd4096);
        send_point(make_point(65536, 65536, 65536));
        send_point(make_point(-65536, -65536, 65536));
        send_point(make_point(1, -1, 32'h7FFFFFFF));
        load_viewport(13'd1, 13'd1);
        send_point(make_point(100, 200, 300));
        send_point(make_point(-65536, -65536, 65536));
        // extreme coefficients drive the row sums to their limits
        load_matrix(coef_pair(32'h80000000, 32'h80000000), coef_pair(32'h80000000, 32'h7FFFFFFF),
                    coef_pair(32'h7FFFFFFF, 32'h7FFFFFFF), coef_pair(32'h7FFFFFFF, 32'h80000000),
                    coef_pair(32'h80000000, 32'h80000000), coef_pair(32'h80000000, 32'h7FFFFFFF));
        send_point(make_point(32'h80000000, 32'h80000000, 32'h80000000));
        send_point(make_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_point(make_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    endtask

    // Camera-like matrix: positive depth term on w, modest x/y terms.
    task automatic load_random_camera();
        load_matrix(coef_pair(small_fixed(2), small_fixed(1)),
                    coef_pair(small_fixed(1), small_fixed(8)),
                    coef_pair(small_fixed(1), small_fixed(2)),
                    coef_pair(small_fixed(1), small_fixed(8)),
                    coef_pair(small_fixed(1) >>> 3, small_fixed(1) >>> 3),
                    coef_pair(int'($urandom_range(16384, 4 * 65536)), small_fixed(4)));
    endtask

    task automatic test_random_points(input int phases, input int per_phase);
        point_t p;
        for (int ph = 0; ph < phases; ph++)
        begin
            if (ph % 4 == 3)
                load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
            else
                load_random_camera();
            case (ph % 3)
                0: load_viewport(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
                1: load_viewport(13'd4096, 13'd1);
                default: load_viewport(13'($urandom), 13'($urandom));
            endcase
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    p = make_point($urandom, $urandom, $urandom);   // noise
                else
                    p = make_point(small_fixed(64), small_fixed(64),
                                   int'($urandom_range(0, 128 * 65536)) - 8 * 65536);
                send_point(p);
                // hold off once mid-phase until the pipeline is empty
                if (ph == 1 && i == per_phase / 2)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (pending_pixels.size() != 0)
                        @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        shadow_regs[REG_X_AB] = '0;
        shadow_regs[REG_X_CD] = '0;
        shadow_regs[REG_Y_AB] = '0;
        shadow_regs[REG_Y_CD] = '0;
        shadow_regs[REG_W_AB] = '0;
        shadow_regs[REG_W_CD] = '0;
        shadow_regs[REG_WIDTH] = 64'(RESET_WIDTH);
        shadow_regs[REG_HEIGHT] = 64'(RESET_HEIGHT);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_edges();
        test_random_points(7, 85);
        // final stretch: back-to-back beats, no idling
        idle_on = 1'b0;
        test_random_points(1, 100);

        drain_pipe();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
